// File: design/gne_pkg.sv
// Shared widths, register indexes and the candidate offset tables of the grid neighbour enumerator.
`timescale 1ns / 1ps

package gne_pkg;

  localparam int IDX_W = 30;
  localparam int SLOT_W = 5;
  localparam int REG_W = 11;
  localparam int MAX_NEIGHBORS = 18;
  localparam int FACE_COUNT = 6;
  localparam int DIV_STEPS = IDX_W;

  localparam logic [10:0] SIZE_RESET = 11'd64;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef logic signed [1:0] offset_t;

  // Face offsets first, then the edge offsets in the remaining slots.
  localparam offset_t OFF_DX [MAX_NEIGHBORS] = '{
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd0,
    -2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1,
    -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1
  };
  localparam offset_t OFF_DY [MAX_NEIGHBORS] = '{
    2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0,
    -2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd0, 2'sd0,
    2'sd1, 2'sd1, -2'sd1, 2'sd1, 2'sd0, 2'sd0
  };
  localparam offset_t OFF_DZ [MAX_NEIGHBORS] = '{
    2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd1,
    2'sd0, 2'sd0, 2'sd1, 2'sd1, -2'sd1, 2'sd1
  };

endpackage

// File: design/grid_neighbor_enumerator.sv
// Top level of the grid neighbour enumerator: sequencer, shared divider and result register.
`timescale 1ns / 1ps

// The block takes the linear index of a vertex in an X*Y*Z grid (x fastest) on the
// input channel (in_valid / in_ready, field vertex_index) and returns, on the output
// channel (out_valid / out_ready), one transfer for each face or edge neighbour that lies
// inside the grid, in the fixed candidate order, with is_last set on the final one.
// A vertex with x+y+z odd only tries its six face neighbours; an even one tries all
// eighteen. An index beyond the grid gives one transfer with bad_index set, and a vertex
// with no neighbour inside the grid gives one transfer with no_neighbor set.
// The grid extents are written through the configuration port (cfg_write, cfg_index,
// cfg_data); the user must write them only while the block is idle, which the block
// itself does not enforce. An extent above 2^COORD_BITS is taken as that cap. The
// extent products X*Y and then X*Y*Z are registered in turn, then the range check runs
// and a bad index result is loaded once the result register is free. Otherwise one shared
// restoring divider, one quotient bit per cycle, decodes x and then y and z, the
// neighbour mask is built in its own state, and the results follow at one candidate
// slot per cycle while the receiver does not stall.
// in_ready is high only while the sequencer is idle. When the receiver stalls the
// sequencer holds its place until the result register frees. Reset sets all three
// extents to 64 and empties the result register.
module grid_neighbor_enumerator #(
  parameter int COORD_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [gne_pkg::REG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gne_pkg::IDX_W-1:0]  vertex_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gne_pkg::IDX_W-1:0]  neighbor_index,
  output logic [gne_pkg::SLOT_W-1:0] offset_slot,
  output logic                       is_last,
  output logic                       no_neighbor,
  output logic                       bad_index
);

  // Effective extent width and coordinate width follow from the saturation cap.
  localparam int EW = (COORD_BITS < gne_pkg::REG_W) ? COORD_BITS + 1 : gne_pkg::REG_W;
  localparam int CW = (COORD_BITS < gne_pkg::REG_W) ? COORD_BITS : gne_pkg::REG_W;
  localparam int TW = 3 * EW;
  localparam int CMPW = (TW > gne_pkg::IDX_W) ? TW : gne_pkg::IDX_W;
  localparam int NW = gne_pkg::IDX_W + 2;
  localparam int NB = gne_pkg::MAX_NEIGHBORS;
  localparam logic [gne_pkg::REG_W-1:0] CAP =
    (COORD_BITS < gne_pkg::REG_W) ? gne_pkg::REG_W'(1 << COORD_BITS) : '1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_CHECK, S_DIV, S_MASK, S_EMIT
  } state_t;

  state_t state;

  logic [gne_pkg::REG_W-1:0] size_x, size_y, size_z;
  logic [EW-1:0] sx, sy, sz;

  logic [gne_pkg::IDX_W-1:0]  idx;
  logic [2*EW-1:0]            sxy;
  logic [TW-1:0]              total;
  logic [EW-1:0]              rem;
  logic [gne_pkg::IDX_W-1:0]  quo;
  logic [4:0]                 cnt;
  logic                       phase;
  logic [CW-1:0]              cx, cy, cz;
  logic [NB-1:0]              mask;
  logic [gne_pkg::SLOT_W-1:0] slot;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= gne_pkg::SIZE_RESET;
      size_y <= gne_pkg::SIZE_RESET;
      size_z <= gne_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        gne_pkg::REG_SIZE_X: size_x <= cfg_data;
        gne_pkg::REG_SIZE_Y: size_y <= cfg_data;
        gne_pkg::REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated extents.
  assign sx = EW'((size_x > CAP) ? CAP : size_x);
  assign sy = EW'((size_y > CAP) ? CAP : size_y);
  assign sz = EW'((size_z > CAP) ? CAP : size_z);

  // Shared restoring divider step: one quotient bit per cycle.
  logic [EW-1:0] divisor;
  logic [EW:0]   rem_sh;
  logic          div_ge;
  logic [EW-1:0] rem_new;
  logic [gne_pkg::IDX_W-1:0] quo_new;

  always_comb begin
    divisor = phase ? sy : sx;
    rem_sh  = {rem, quo[gne_pkg::IDX_W-1]};
    div_ge  = (rem_sh >= {1'b0, divisor});
    rem_new = div_ge ? EW'(rem_sh - {1'b0, divisor}) : rem_sh[EW-1:0];
    quo_new = {quo[gne_pkg::IDX_W-2:0], div_ge};
  end

  // A coordinate stays inside its extent after a step of d.
  function automatic logic axis_ok(input logic [CW-1:0] c, input gne_pkg::offset_t d,
                                   input logic [EW-1:0] s);
    logic [EW:0] up;
    up = (EW+1)'(c) + (EW+1)'(1);
    if (d < 0) return (c != '0);
    else if (d > 0) return (up < (EW+1)'(s));
    else return 1'b1;
  endfunction

  logic          odd_sum;
  logic [NB-1:0] mask_next;

  always_comb begin
    odd_sum = cx[0] ^ cy[0] ^ cz[0];
    for (int k = 0; k < NB; k++) begin
      mask_next[k] = ((k < gne_pkg::FACE_COUNT) || !odd_sum) &&
                     axis_ok(cx, gne_pkg::OFF_DX[k], sx) &&
                     axis_ok(cy, gne_pkg::OFF_DY[k], sy) &&
                     axis_ok(cz, gne_pkg::OFF_DZ[k], sz);
    end
  end

  // Neighbour index is the query index moved by dx + dy*X + dz*X*Y.
  gne_pkg::offset_t dx, dy, dz;
  logic [NW-1:0] term_x, term_y, term_z, nb_sum;
  logic [NB-1:0] mask_rest;
  logic          slot_last;

  always_comb begin
    dx = gne_pkg::OFF_DX[slot];
    dy = gne_pkg::OFF_DY[slot];
    dz = gne_pkg::OFF_DZ[slot];
    term_x = (dx < 0) ? '1 : ((dx > 0) ? NW'(1) : '0);
    term_y = (dy < 0) ? -NW'(sx) : ((dy > 0) ? NW'(sx) : '0);
    term_z = (dz < 0) ? -NW'(sxy) : ((dz > 0) ? NW'(sxy) : '0);
    nb_sum = NW'(idx) + term_x + term_y + term_z;
    mask_rest = mask >> slot;
    slot_last = (mask_rest[NB-1:1] == '0);
  end

  logic out_free;
  logic bad_hit;
  logic out_load;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign bad_hit  = (CMPW'(idx) >= CMPW'(total));

  // A new result enters the result register in this cycle.
  always_comb begin
    case (state)
      S_CHECK: out_load = out_free && bad_hit;
      S_MASK:  out_load = out_free && (mask_next == '0);
      S_EMIT:  out_load = out_free && mask[slot];
      default: out_load = 1'b0;
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx   <= vertex_index;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          sxy   <= (2*EW)'(sx) * (2*EW)'(sy);
          state <= S_MUL2;
        end
        S_MUL2: begin
          total <= TW'(sxy) * TW'(sz);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (bad_hit) begin
            if (out_free) begin
              neighbor_index <= '0;
              offset_slot    <= '0;
              is_last        <= 1'b1;
              no_neighbor    <= 1'b0;
              bad_index      <= 1'b1;
              state          <= S_IDLE;
            end
          end else begin
            rem   <= '0;
            quo   <= idx;
            cnt   <= '0;
            phase <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 5'(gne_pkg::DIV_STEPS - 1)) begin
            cnt <= '0;
            rem <= '0;
            if (!phase) begin
              // First pass leaves x in the remainder and y + Y*z in the quotient.
              cx    <= rem_new[CW-1:0];
              quo   <= quo_new;
              phase <= 1'b1;
            end else begin
              cy    <= rem_new[CW-1:0];
              cz    <= quo_new[CW-1:0];
              state <= S_MASK;
            end
          end else begin
            cnt <= cnt + 5'd1;
            rem <= rem_new;
            quo <= quo_new;
          end
        end
        S_MASK: begin
          mask <= mask_next;
          slot <= '0;
          if (mask_next == '0) begin
            if (out_free) begin
              neighbor_index <= '0;
              offset_slot    <= '0;
              is_last        <= 1'b1;
              no_neighbor    <= 1'b1;
              bad_index      <= 1'b0;
              state          <= S_IDLE;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!mask[slot]) begin
            slot <= slot + gne_pkg::SLOT_W'(1);
          end else if (out_free) begin
            neighbor_index <= nb_sum[gne_pkg::IDX_W-1:0];
            offset_slot    <= slot;
            is_last        <= slot_last;
            no_neighbor    <= 1'b0;
            bad_index      <= 1'b0;
            if (slot_last) state <= S_IDLE;
            else slot <= slot + gne_pkg::SLOT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The two special results never coincide.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_index && no_neighbor))
    else $error("bad_index and no_neighbor raised together");

  // A special result is a single, empty, final transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (bad_index || no_neighbor) |->
      is_last && (neighbor_index == '0) && (offset_slot == '0))
    else $error("special result is not a lone empty transfer");

  // Slots stay within the candidate table.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (offset_slot < gne_pkg::SLOT_W'(NB)))
    else $error("offset_slot beyond the candidate table");

  // A waiting result keeps its payload until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable({neighbor_index, offset_slot, is_last, no_neighbor, bad_index}))
    else $error("result changed while the receiver stalled");

endmodule
